[design/dpjf_pkg.sv]
package dpjf_pkg;

   localparam int ELEM_W    = 32;
   localparam int PROD_W    = 64;
   localparam int ID_W      = 24;
   localparam int NORM_W    = 48;
   localparam int SUM_W     = 49;
   localparam int LEN_W     = 13;
   localparam int SCORE_W   = 17;
   localparam int PORT_LANES = 4;
   localparam int CSR_IDX_W = 2;

   localparam logic OPC_QUERY = 1'b0;
   localparam logic OPC_CAND  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_POS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUERY_NORM    = 2'd2;

   localparam logic [SCORE_W-1:0] SCORE_ONE = 17'h10000;
   localparam logic [PROD_W-1:0]  QM_CAP    = 64'd1 << 50;

   typedef struct packed {
      logic               keep;
      logic [ID_W-1:0]    id;
      logic [SCORE_W-1:0] score;
   } dpjf_res_type;

endpackage

[design/dpjf_lane.sv]
module dpjf_lane #(
   parameter int ROWS  = 1024,
   parameter int ROW_W = 10
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [ROW_W-1:0]               wr_row,
   input  logic [dpjf_pkg::ELEM_W-1:0]    wr_data,
   input  logic                           rd_en,
   input  logic [ROW_W-1:0]               rd_row,
   input  logic [dpjf_pkg::ELEM_W-1:0]    cand_data,
   output logic [dpjf_pkg::PROD_W-1:0]    prod
);

   logic [dpjf_pkg::ELEM_W-1:0] mem [ROWS];
   logic [dpjf_pkg::ELEM_W-1:0] q_ff;
   logic [dpjf_pkg::ELEM_W-1:0] c_ff;
   logic [dpjf_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_row] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff <= mem[rd_row];
         c_ff <= cand_data;
      end
   end

   // signed 32x32, registered; operands sign-extend to the 64-bit target
   always_ff @(posedge clock) begin
      prod_ff <= $signed(q_ff) * $signed(c_ff);
   end

   assign prod = prod_ff;

endmodule

[design/dpjf_merge.sv]
module dpjf_merge #(
   parameter int LANES = 4
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [LANES-1:0][dpjf_pkg::PROD_W-1:0]   prod,
   input  logic                                     prod_valid,
   input  logic                                     prod_fin,
   output logic                                     dot_valid,
   output logic [dpjf_pkg::PROD_W-1:0]              dot
);

   logic [dpjf_pkg::PROD_W-1:0] sum_in;
   logic [dpjf_pkg::PROD_W-1:0] sum_ff;
   logic                        s3_valid_ff;
   logic                        s3_fin_ff;
   logic [dpjf_pkg::PROD_W-1:0] acc_ff;
   logic [dpjf_pkg::PROD_W-1:0] total;
   logic [dpjf_pkg::PROD_W-1:0] dot_ff;
   logic                        dot_valid_ff;

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < LANES; i++) begin
         sum_in = sum_in + prod[i];
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign total = acc_ff + sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         s3_fin_ff    <= 1'b0;
         acc_ff       <= '0;
         dot_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff  <= prod_valid;
         s3_fin_ff    <= prod_fin;
         dot_valid_ff <= 1'b0;
         if (s3_valid_ff) begin
            if (s3_fin_ff) begin
               acc_ff       <= '0;
               dot_valid_ff <= 1'b1;
            end else begin
               acc_ff <= total;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_valid_ff && s3_fin_ff) begin
         dot_ff <= total;
      end
   end

   assign dot_valid = dot_valid_ff;
   assign dot       = dot_ff;

endmodule

[design/dpjf_final.sv]
module dpjf_final #(
   parameter int NORM_FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [dpjf_pkg::PROD_W-1:0]       dot,
   input  logic [dpjf_pkg::LEN_W-1:0]        vec_len,
   input  logic [dpjf_pkg::ID_W-1:0]         query_pos,
   input  logic [dpjf_pkg::NORM_W-1:0]       query_norm,
   input  logic [dpjf_pkg::ID_W-1:0]         cand_id,
   input  logic [dpjf_pkg::NORM_W-1:0]       cand_norm,
   output logic                              res_valid,
   input  logic                              res_take,
   output dpjf_pkg::dpjf_res_type            res
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_CHK  = 3'd2;
   localparam logic [2:0] ST_PREP = 3'd3;
   localparam logic [2:0] ST_SDIV = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   localparam int W = dpjf_pkg::PROD_W;

   logic [2:0]                     state_ff, state_in;
   logic [5:0]                     cnt_ff, cnt_in;
   logic [W-1:0]                   dvd_ff, dvd_in;
   logic [dpjf_pkg::LEN_W-1:0]     rem_ff, rem_in;
   logic [dpjf_pkg::LEN_W-1:0]     len_ff, len_in;
   logic [dpjf_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic [W-1:0]                   dot_ff, dot_in;
   logic [W-1:0]                   b_ff, b_in;
   logic [W-1:0]                   r_ff, r_in;
   logic [W-1:0]                   d_ff, d_in;
   logic [15:0]                    q_ff, q_in;
   logic                           keep_ff, keep_in;
   logic                           sat_ff, sat_in;
   logic [dpjf_pkg::ID_W-1:0]      id_ff, id_in;

   logic [dpjf_pkg::LEN_W:0]       trial;
   logic                           trial_ge;
   logic [W-1:0]                   qm20;
   logic [W-1:0]                   a_val;
   logic [W-1:0]                   d_val;
   logic [W-1:0]                   r2;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      len_in   = len_ff;
      sum_in   = sum_ff;
      dot_in   = dot_ff;
      b_in     = b_ff;
      r_in     = r_ff;
      d_in     = d_ff;
      q_in     = q_ff;
      keep_in  = keep_ff;
      sat_in   = sat_ff;
      id_in    = id_ff;
      trial    = {rem_ff, dvd_ff[W-1]};
      trial_ge = trial >= {1'b0, len_ff};
      qm20     = (dvd_ff << 4) + (dvd_ff << 2);
      a_val    = dot_ff << NORM_FRAC_BITS;
      d_val    = b_ff - a_val;
      r2       = r_ff << 1;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dot_in  = dot;
               dvd_in  = dot;
               rem_in  = '0;
               len_in  = (vec_len == '0) ? dpjf_pkg::LEN_W'(1) : vec_len;
               sum_in  = {1'b0, query_norm} + {1'b0, cand_norm};
               id_in   = cand_id;
               cnt_in  = '0;
               keep_in = 1'b0;
               if (cand_id == query_pos || dot[W-1]) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit a cycle
            rem_in = trial_ge ? dpjf_pkg::LEN_W'(trial - {1'b0, len_ff})
                              : trial[dpjf_pkg::LEN_W-1:0];
            dvd_in = {dvd_ff[W-2:0], trial_ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            keep_in = (dvd_ff != '0) &&
                      ((dvd_ff > dpjf_pkg::QM_CAP) ||
                       (qm20 > W'(sum_ff >> NORM_FRAC_BITS)));
            b_in    = W'(sum_ff) * W'(len_ff);
            sat_in  = (dot_ff >> (W - 1 - NORM_FRAC_BITS)) != '0;
            state_in = (dvd_ff != '0 &&
                        ((dvd_ff > dpjf_pkg::QM_CAP) ||
                         (qm20 > W'(sum_ff >> NORM_FRAC_BITS)))) ? ST_PREP : ST_DONE;
         end
         ST_PREP: begin
            if (sat_ff || a_val >= b_ff || a_val >= d_val) begin
               sat_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               d_in     = d_val;
               r_in     = a_val;
               q_in     = '0;
               cnt_in   = '0;
               state_in = ST_SDIV;
            end
         end
         ST_SDIV: begin
            r_in   = (r2 >= d_ff) ? r2 - d_ff : r2;
            q_in   = {q_ff[14:0], r2 >= d_ff};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd15) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         keep_ff  <= 1'b0;
         sat_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         keep_ff  <= keep_in;
         sat_ff   <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      len_ff <= len_in;
      sum_ff <= sum_in;
      dot_ff <= dot_in;
      b_ff   <= b_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
      id_ff  <= id_in;
   end

   assign res_valid = (state_ff == ST_DONE);
   assign res.keep  = keep_ff;
   assign res.id    = id_ff;
   assign res.score = sat_ff ? dpjf_pkg::SCORE_ONE : {1'b0, q_ff};

endmodule

[design/dot_product_jaccard_filter.sv]
// Channel   Handshake              Carries
// req_      req_valid/req_stall    query or candidate chunk, ids, norm
// rsp_      rsp_valid/rsp_stall    neighbour id and Tanimoto score
// csr_      csr_valid/csr_ready    register index and write data
//
// Non-final chunks are taken at one transaction a cycle (read, multiply, lane
// sum, accumulate). A candidate's final chunk holds req_stall high until the
// scoring sequencer is done: 64-step quotient divider, 16-step score divider;
// a saturating score skips the score divider, a threshold reject also skips
// it, and a self-pair or negative dot product skips both dividers.
// Synchronous reset clears pointers, accumulator and control, not the query
// store. A result held by rsp_stall delays the sequencer and so req_stall.
module dot_product_jaccard_filter #(
   parameter int LANES          = 4,
   parameter int MAX_DIM        = 4096,
   parameter int NORM_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_opcode,
   input  logic signed [dpjf_pkg::ELEM_W-1:0]   req_lane_0,
   input  logic signed [dpjf_pkg::ELEM_W-1:0]   req_lane_1,
   input  logic signed [dpjf_pkg::ELEM_W-1:0]   req_lane_2,
   input  logic signed [dpjf_pkg::ELEM_W-1:0]   req_lane_3,
   input  logic                                 req_final_chunk,
   input  logic [dpjf_pkg::ID_W-1:0]            req_candidate_id,
   input  logic [dpjf_pkg::NORM_W-1:0]          req_candidate_norm_squared,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [dpjf_pkg::ID_W-1:0]            rsp_neighbor_id,
   output logic [dpjf_pkg::SCORE_W-1:0]         rsp_similarity,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dpjf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dpjf_pkg::NORM_W-1:0]          csr_data
);

   // query store is banked by lane: one row holds one chunk
   localparam int ROWS  = MAX_DIM / LANES;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic                              accept;
   logic                              acc_query;
   logic                              acc_cand;

   logic [ROW_W-1:0]                  load_row_ff, load_row_in;
   logic [ROW_W-1:0]                  chunk_row_ff, chunk_row_in;

   logic [dpjf_pkg::LEN_W-1:0]        vec_len_ff;
   logic [dpjf_pkg::ID_W-1:0]         query_pos_ff;
   logic [dpjf_pkg::NORM_W-1:0]       query_norm_ff;

   logic                              s1_valid_ff, s1_fin_ff;
   logic                              s2_valid_ff, s2_fin_ff;
   logic                              pend_ff;
   logic [dpjf_pkg::ID_W-1:0]         hold_id_ff;
   logic [dpjf_pkg::NORM_W-1:0]       hold_norm_ff;

   logic [dpjf_pkg::PORT_LANES-1:0][dpjf_pkg::ELEM_W-1:0] port_lane;
   logic [LANES-1:0][dpjf_pkg::PROD_W-1:0]                lane_prod;

   logic                              dot_valid;
   logic [dpjf_pkg::PROD_W-1:0]       dot;
   logic                              res_valid;
   logic                              res_take;
   dpjf_pkg::dpjf_res_type            res;

   logic                              rsp_valid_ff;
   logic [dpjf_pkg::ID_W-1:0]         rsp_id_ff;
   logic [dpjf_pkg::SCORE_W-1:0]      rsp_sim_ff;

   assign accept    = req_valid && !req_stall;
   assign acc_query = accept && (req_opcode == dpjf_pkg::OPC_QUERY);
   assign acc_cand  = accept && (req_opcode == dpjf_pkg::OPC_CAND);
   assign req_stall = pend_ff;
   assign csr_ready = 1'b1;

   assign port_lane[0] = req_lane_0;
   assign port_lane[1] = req_lane_1;
   assign port_lane[2] = req_lane_2;
   assign port_lane[3] = req_lane_3;

   // pointers wrap over the store; a final chunk rewinds them
   always_comb begin
      load_row_in  = load_row_ff;
      chunk_row_in = chunk_row_ff;
      if (acc_query) begin
         if (req_final_chunk || load_row_ff == ROW_W'(ROWS - 1)) begin
            load_row_in = '0;
         end else begin
            load_row_in = load_row_ff + ROW_W'(1);
         end
      end
      if (acc_cand) begin
         if (req_final_chunk || chunk_row_ff == ROW_W'(ROWS - 1)) begin
            chunk_row_in = '0;
         end else begin
            chunk_row_in = chunk_row_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_row_ff   <= '0;
         chunk_row_ff  <= '0;
         vec_len_ff    <= dpjf_pkg::LEN_W'(1);
         query_pos_ff  <= '0;
         query_norm_ff <= '0;
         s1_valid_ff   <= 1'b0;
         s1_fin_ff     <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s2_fin_ff     <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         load_row_ff  <= load_row_in;
         chunk_row_ff <= chunk_row_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dpjf_pkg::CSR_VECTOR_LENGTH: vec_len_ff <= csr_data[dpjf_pkg::LEN_W-1:0];
               dpjf_pkg::CSR_QUERY_POS:     query_pos_ff <= csr_data[dpjf_pkg::ID_W-1:0];
               dpjf_pkg::CSR_QUERY_NORM:    query_norm_ff <= csr_data;
               default: begin
               end
            endcase
         end
         s1_valid_ff <= acc_cand;
         s1_fin_ff   <= req_final_chunk;
         s2_valid_ff <= s1_valid_ff;
         s2_fin_ff   <= s1_fin_ff;
         if (acc_cand && req_final_chunk) begin
            pend_ff <= 1'b1;
         end else if (res_take) begin
            pend_ff <= 1'b0;
         end
         if (res_take && res.keep) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // id and norm of the closing candidate stay put while the sequencer runs
   always_ff @(posedge clock) begin
      if (acc_cand && req_final_chunk) begin
         hold_id_ff   <= req_candidate_id;
         hold_norm_ff <= req_candidate_norm_squared;
      end
      if (res_take && res.keep) begin
         rsp_id_ff  <= res.id;
         rsp_sim_ff <= res.score;
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      logic [dpjf_pkg::ELEM_W-1:0] lane_data;
      if (g < dpjf_pkg::PORT_LANES) begin : g_port
         assign lane_data = port_lane[g];
      end else begin : g_pad
         assign lane_data = '0;
      end
      dpjf_lane #(
         .ROWS  (ROWS),
         .ROW_W (ROW_W)
      ) u_lane (
         .clock     (clock),
         .wr_en     (acc_query),
         .wr_row    (load_row_ff),
         .wr_data   (lane_data),
         .rd_en     (acc_cand),
         .rd_row    (chunk_row_ff),
         .cand_data (lane_data),
         .prod      (lane_prod[g])
      );
   end

   dpjf_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .prod       (lane_prod),
      .prod_valid (s2_valid_ff),
      .prod_fin   (s2_fin_ff),
      .dot_valid  (dot_valid),
      .dot        (dot)
   );

   // result leaves the sequencer once the output register is free
   assign res_take = res_valid && (!rsp_valid_ff || !rsp_stall);

   dpjf_final #(
      .NORM_FRAC_BITS (NORM_FRAC_BITS)
   ) u_final (
      .clock      (clock),
      .reset      (reset),
      .start      (dot_valid),
      .dot        (dot),
      .vec_len    (vec_len_ff),
      .query_pos  (query_pos_ff),
      .query_norm (query_norm_ff),
      .cand_id    (hold_id_ff),
      .cand_norm  (hold_norm_ff),
      .res_valid  (res_valid),
      .res_take   (res_take),
      .res        (res)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_neighbor_id = rsp_id_ff;
   assign rsp_similarity  = rsp_sim_ff;

endmodule

[tb/dot_product_jaccard_filter_tb.sv]
module dot_product_jaccard_filter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIM        = 4096;
   localparam int FRAC       = 16;
   localparam int CYCLE_CAP  = 1000000;
   // a final chunk keeps the block busy until its candidate is scored
   localparam int DRAIN_WAIT = 150;
   // query chunks written before the random part; reads stay below this
   localparam int FILL_CHUNKS = 48;

   typedef struct {
      logic                               opcode;
      logic signed [dpjf_pkg::ELEM_W-1:0] lane [dpjf_pkg::PORT_LANES];
      logic                               fin;
      logic [dpjf_pkg::ID_W-1:0]          id;
      logic [dpjf_pkg::NORM_W-1:0]        norm;
   } chunk_type;

   typedef struct {
      logic [dpjf_pkg::ID_W-1:0]    id;
      logic [dpjf_pkg::SCORE_W-1:0] score;
   } neighbour_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic                               req_opcode = dpjf_pkg::OPC_QUERY;
   logic signed [dpjf_pkg::ELEM_W-1:0] req_lane_0 = '0;
   logic signed [dpjf_pkg::ELEM_W-1:0] req_lane_1 = '0;
   logic signed [dpjf_pkg::ELEM_W-1:0] req_lane_2 = '0;
   logic signed [dpjf_pkg::ELEM_W-1:0] req_lane_3 = '0;
   logic                               req_final_chunk = 1'b0;
   logic [dpjf_pkg::ID_W-1:0]          req_candidate_id = '0;
   logic [dpjf_pkg::NORM_W-1:0]        req_candidate_norm_squared = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [dpjf_pkg::ID_W-1:0]          rsp_neighbor_id;
   logic [dpjf_pkg::SCORE_W-1:0]       rsp_similarity;
   logic                               csr_valid = 1'b0;
   logic                               csr_ready;
   logic [dpjf_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [dpjf_pkg::NORM_W-1:0]        csr_data = '0;

   dot_product_jaccard_filter dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow state of the filter: query memory, pointers, running dot sum
   // and the three registers.
   // ---------------------------------------------------------------------
   logic [dpjf_pkg::ELEM_W-1:0] q_mem [DIM];
   int unsigned                 q_load_ptr;
   int unsigned                 cand_ptr;
   logic [63:0]                 dot_sum;
   logic [dpjf_pkg::LEN_W-1:0]  len_reg;
   logic [dpjf_pkg::ID_W-1:0]   self_id;
   logic [dpjf_pkg::NORM_W-1:0] q_norm;

   chunk_type     pending_chunks [$];
   neighbour_type due_neighbours [$];
   int            n_errors;
   bit            calm;   // no idling on either side while set

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      n_errors++;
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
   endtask

   // Q1.16 Tanimoto score, saturating at 1.0
   function automatic logic [dpjf_pkg::SCORE_W-1:0] tanimoto(input logic [63:0] dot,
                                                             input logic [63:0] sum,
                                                             input logic [63:0] len);
      logic [63:0] num, den, rem, quo;
      den = sum * len;
      if ((dot >> (63 - FRAC)) != 0) return dpjf_pkg::SCORE_ONE;
      num = dot << FRAC;
      if (num >= den) return dpjf_pkg::SCORE_ONE;
      den = den - num;
      if (num >= den) return dpjf_pkg::SCORE_ONE;
      rem = num;
      quo = '0;
      for (int i = 0; i < 16; i++) begin
         rem = rem << 1;
         quo = quo << 1;
         if (rem >= den) begin
            rem = rem - den;
            quo[0] = 1'b1;
         end
      end
      return quo[dpjf_pkg::SCORE_W-1:0];
   endfunction

   task automatic absorb_chunk(input chunk_type c);
      logic [63:0]   len, sum, qm, dot;
      longint        prod;
      neighbour_type hit;
      if (c.opcode == dpjf_pkg::OPC_QUERY) begin
         for (int i = 0; i < dpjf_pkg::PORT_LANES; i++)
            q_mem[(q_load_ptr + i) % DIM] = c.lane[i];
         q_load_ptr = c.fin ? 0 : (q_load_ptr + dpjf_pkg::PORT_LANES) % DIM;
         return;
      end
      for (int i = 0; i < dpjf_pkg::PORT_LANES; i++) begin
         prod = longint'(c.lane[i]) * longint'($signed(q_mem[(cand_ptr + i) % DIM]));
         dot_sum = dot_sum + prod;
      end
      cand_ptr = (cand_ptr + dpjf_pkg::PORT_LANES) % DIM;
      if (!c.fin) return;
      dot      = dot_sum;
      dot_sum  = '0;
      cand_ptr = 0;
      len = (len_reg == 0) ? 64'd1 : 64'(len_reg);
      sum = 64'(q_norm) + 64'(c.norm);
      if (c.id == self_id || dot[63]) return;
      qm = dot / len;
      if (qm == 0) return;
      if (!(qm > dpjf_pkg::QM_CAP || qm * 20 > (sum >> FRAC))) return;
      hit.id    = c.id;
      hit.score = tanimoto(dot, sum, len);
      due_neighbours.insert(due_neighbours.size(), hit);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: presents queued chunks, holds them while stalled and
   // feeds each accepted transaction into the shadow model.
   // ---------------------------------------------------------------------
   chunk_type on_bus;
   int        req_gap;

   always @(posedge clock) begin
      chunk_type nx;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall) absorb_chunk(on_bus);
         if (req_valid && req_stall) begin
            // payload held
         end else if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_chunks.size() != 0) begin
            nx = pending_chunks.pop_front();
            on_bus = nx;
            req_opcode                 <= nx.opcode;
            req_lane_0                 <= nx.lane[0];
            req_lane_1                 <= nx.lane[1];
            req_lane_2                 <= nx.lane[2];
            req_lane_3                 <= nx.lane[3];
            req_final_chunk            <= nx.fin;
            req_candidate_id           <= nx.id;
            req_candidate_norm_squared <= nx.norm;
            req_valid <= 1'b1;
            req_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor with random back-pressure.
   // ---------------------------------------------------------------------
   int rsp_hold;

   always @(posedge clock) begin
      neighbour_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (due_neighbours.size() == 0) begin
               report("unexpected neighbour id", rsp_neighbor_id, 0);
            end else begin
               want = due_neighbours.pop_front();
               if (rsp_neighbor_id !== want.id)
                  report("neighbor_id", rsp_neighbor_id, want.id);
               if (rsp_similarity !== want.score)
                  report("similarity", rsp_similarity, want.score);
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 99) < 30) rsp_hold = pick_gap();
         end
      end
   end

   int unsigned n_cycles;
   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles >= CYCLE_CAP) begin
         $display("** dot_product_jaccard_filter: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers. The generator keeps its own copy of the query so
   // candidates can be made to resemble it and actually pass the filter.
   // gen_cp follows the candidate chunk pointer, in chunks.
   // ---------------------------------------------------------------------
   logic [dpjf_pkg::ELEM_W-1:0] gen_query [DIM];
   int unsigned                 gen_lp;
   int unsigned                 gen_cp;

   task automatic wait_quiet();
      while (pending_chunks.size() != 0 || req_valid || due_neighbours.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_csr(input logic [dpjf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [dpjf_pkg::NORM_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         dpjf_pkg::CSR_VECTOR_LENGTH: len_reg = val[dpjf_pkg::LEN_W-1:0];
         dpjf_pkg::CSR_QUERY_POS:     self_id = val[dpjf_pkg::ID_W-1:0];
         dpjf_pkg::CSR_QUERY_NORM:    q_norm  = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   function automatic logic [dpjf_pkg::ELEM_W-1:0] rand_elem(input int style);
      case (style)
         0: return $urandom;
         1: return dpjf_pkg::ELEM_W'($signed($urandom_range(0, 2000)) - 1000);
         default: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'hffff_ffff;
               default: return 32'h0;
            endcase
         end
      endcase
   endfunction

   function automatic logic [dpjf_pkg::NORM_W-1:0] rand_norm();
      logic [dpjf_pkg::NORM_W-1:0] n;
      n = dpjf_pkg::NORM_W'({$urandom, $urandom});
      case ($urandom_range(0, 3))
         0: return '0;
         1: return n;
         default: return n >> $urandom_range(0, dpjf_pkg::NORM_W - 1);
      endcase
   endfunction

   task automatic push_query(input int chunks, input int style);
      chunk_type c;
      for (int k = 0; k < chunks; k++) begin
         c.opcode = dpjf_pkg::OPC_QUERY;
         foreach (c.lane[i]) c.lane[i] = rand_elem(style);
         c.fin  = (k == chunks - 1);
         c.id   = dpjf_pkg::ID_W'($urandom);
         c.norm = rand_norm();
         for (int i = 0; i < dpjf_pkg::PORT_LANES; i++)
            gen_query[(gen_lp + i) % DIM] = c.lane[i];
         gen_lp = c.fin ? 0 : (gen_lp + dpjf_pkg::PORT_LANES) % DIM;
         pending_chunks.insert(pending_chunks.size(), c);
      end
   endtask

   // look: 0 copies the query, 1 negates it, 2 is unrelated content
   task automatic push_candidate(input int chunks, input logic [dpjf_pkg::ID_W-1:0] id,
                                 input logic [dpjf_pkg::NORM_W-1:0] norm, input int look,
                                 input bit close);
      chunk_type c;
      for (int k = 0; k < chunks; k++) begin
         c.opcode = dpjf_pkg::OPC_CAND;
         foreach (c.lane[i]) begin
            case (look)
               0: c.lane[i] = gen_query[(k * dpjf_pkg::PORT_LANES + i) % DIM];
               1: c.lane[i] = -gen_query[(k * dpjf_pkg::PORT_LANES + i) % DIM];
               default: c.lane[i] = rand_elem($urandom_range(0, 2));
            endcase
         end
         c.fin  = close && (k == chunks - 1);
         c.id   = id;
         c.norm = norm;
         gen_cp = c.fin ? 0 : (gen_cp + 1) % (DIM / dpjf_pkg::PORT_LANES);
         pending_chunks.insert(pending_chunks.size(), c);
      end
   endtask

   initial begin
      logic [dpjf_pkg::ID_W-1:0] pick;
      n_errors = 0;
      calm = 1'b0;
      gen_lp = 0;
      gen_cp = 0;
      q_load_ptr = 0;
      cand_ptr = 0;
      dot_sum = '0;
      len_reg = 1;
      self_id = '0;
      q_norm = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // --- directed part: one-chunk vectors only, every read was written ---
      write_csr(dpjf_pkg::CSR_VECTOR_LENGTH, 48'd4);
      write_csr(dpjf_pkg::CSR_QUERY_POS, 48'd5);
      write_csr(dpjf_pkg::CSR_QUERY_NORM, '0);
      push_query(1, 2);                                          // extreme values
      push_candidate(1, 24'd5, '0, 0, 1'b1);                     // self-pair
      push_candidate(1, 24'd6, '0, 0, 1'b1);                     // zero norms: saturates
      push_candidate(1, 24'd7, 48'hffff_ffff_ffff, 0, 1'b1);     // huge norm: rejected
      push_candidate(1, 24'd8, 48'h1_0000, 1, 1'b1);             // negative dot
      push_candidate(1, 24'hffffff, 48'h0000_0100_0000, 2, 1'b1);
      push_query(1, 1);                                          // modest values
      push_candidate(1, 24'd9, 48'h0000_0010_0000, 0, 1'b1);
      push_candidate(1, 24'h000000, 48'h0000_0001_0000, 0, 1'b1);
      wait_quiet();

      // dot sum wraps: four products of (-2^31)^2
      write_csr(dpjf_pkg::CSR_VECTOR_LENGTH, 48'd0);             // zero acts as one
      write_csr(dpjf_pkg::CSR_QUERY_POS, 48'hff_ffff);
      write_csr(dpjf_pkg::CSR_QUERY_NORM, 48'hffff_ffff_ffff);
      begin
         chunk_type c;
         c.opcode = dpjf_pkg::OPC_QUERY;
         foreach (c.lane[i]) c.lane[i] = 32'h8000_0000;
         c.fin = 1'b1;
         c.id = '0;
         c.norm = '0;
         pending_chunks.insert(pending_chunks.size(), c);
         foreach (gen_query[i]) if (i < dpjf_pkg::PORT_LANES) gen_query[i] = 32'h8000_0000;
      end
      push_candidate(1, 24'd3, '0, 0, 1'b1);
      push_candidate(1, 24'd4, 48'hffff_ffff_ffff, 0, 1'b1);
      wait_quiet();

      // Write the low part of the query memory so that the longer and broken
      // candidates of the random part only read entries that hold data.
      calm = 1'b1;
      push_query(FILL_CHUNKS, 1);
      wait_quiet();
      calm = 1'b0;

      // --- random part: phases of fresh settings, each ending fully drained ---
      for (int ph = 0; ph < 9; ph++) begin
         int qn, n;
         calm = (ph % 4 == 3);
         qn = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 6);
         case ($urandom_range(0, 4))
            0: write_csr(dpjf_pkg::CSR_VECTOR_LENGTH,
                         dpjf_pkg::NORM_W'($urandom_range(0, 8191)));
            1: write_csr(dpjf_pkg::CSR_VECTOR_LENGTH, 48'd4096);
            2: write_csr(dpjf_pkg::CSR_VECTOR_LENGTH, 48'd1);
            default: write_csr(dpjf_pkg::CSR_VECTOR_LENGTH,
                               dpjf_pkg::NORM_W'(qn * dpjf_pkg::PORT_LANES));
         endcase
         write_csr(dpjf_pkg::CSR_QUERY_POS,
                   (ph == 1) ? 48'h0 : dpjf_pkg::NORM_W'(dpjf_pkg::ID_W'($urandom)));
         write_csr(dpjf_pkg::CSR_QUERY_NORM, (ph == 2) ? 48'hffff_ffff_ffff : rand_norm());
         push_query(qn, $urandom_range(0, 2));
         n = 0;
         while (n < 36) begin
            int r, len;
            r = $urandom_range(0, 99);
            len = (r < 80) ? qn : $urandom_range(1, qn + 2);
            pick = ($urandom_range(0, 9) == 0) ? self_id : dpjf_pkg::ID_W'($urandom);
            // a run of broken vectors is kept short so reads stay in written rows
            if (r >= 90 && r < 95 && gen_cp >= 8) r = 0;
            if (r < 90) begin
               push_candidate(len, pick, rand_norm(),
                              (r < 60) ? 0 : (r < 70) ? 1 : 2, 1'b1);
            end else if (r < 95) begin
               // broken vector: a chunk without a close, then a stray query chunk
               push_candidate(1, pick, rand_norm(), 2, 1'b0);
               push_query(1, $urandom_range(0, 2));
            end else begin
               push_query(qn, $urandom_range(0, 2));
            end
            n += len;
         end
         wait_quiet();
      end

      if (n_errors == 0 && due_neighbours.size() == 0)
         $display("** dot_product_jaccard_filter: PASSED **");
      else
         $display("** dot_product_jaccard_filter: FAILED **");
      $finish;
   end

endmodule
